/* rtl/core/slfp_pkg.sv */
// Shared types and constants for the sync/length frame parser.
// No dependencies; used by slfp_tracker and sync_length_frame_parser.
`default_nettype none

package slfp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned AZ_W      = 32;
    localparam int unsigned AZ_BYTES  = 4;
    localparam int unsigned CFG_IDX_W = 2;

    // Register reset values
    localparam logic [BYTE_W-1:0] FIRST_SYNC_RESET  = 8'hEE;
    localparam logic [BYTE_W-1:0] SECOND_SYNC_RESET = 8'hEF;
    localparam logic [BYTE_W-1:0] END_BYTE_RESET    = 8'hFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_SYNC  = 2'd0,
        REG_SECOND_SYNC = 2'd1,
        REG_END_BYTE    = 2'd2
    } reg_index_t;

    // Frame tracking phases, one-hot
    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_SYNC1   = 7'b0000010,
        PH_TYPE    = 7'b0000100,
        PH_LENGTH  = 7'b0001000,
        PH_PAYLOAD = 7'b0010000,
        PH_CHECK   = 7'b0100000,
        PH_END     = 7'b1000000
    } phase_t;

    // Match values for the framing bytes
    typedef struct packed {
        logic [BYTE_W-1:0] first_sync;
        logic [BYTE_W-1:0] second_sync;
        logic [BYTE_W-1:0] end_byte;
    } cfg_t;

    // One completed frame
    typedef struct packed {
        logic              azimuth_present;
        logic [AZ_W-1:0]   azimuth_bits;
        logic [BYTE_W-1:0] checksum_value;
        logic [BYTE_W-1:0] payload_length;
        logic [BYTE_W-1:0] frame_type;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/slfp_tracker.sv */
// Frame state tracker: follows sync, type, length, payload, checksum and end bytes.
// Depends on slfp_pkg.
`default_nettype none

module slfp_tracker
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                byte_valid,
    input  wire  [slfp_pkg::BYTE_W-1:0]        rx_byte,
    input  wire  slfp_pkg::cfg_t               cfg,
    output logic                               emit,
    output slfp_pkg::result_t                  result,
    output slfp_pkg::phase_t                   phase
);

    slfp_pkg::phase_t                 phase_reg,    phase_next;
    logic [slfp_pkg::BYTE_W-1:0]      type_reg,     type_next;
    logic [slfp_pkg::BYTE_W-1:0]      length_reg,   length_next;
    logic [slfp_pkg::BYTE_W-1:0]      count_reg,    count_next;
    logic [slfp_pkg::AZ_W-1:0]        azimuth_reg,  azimuth_next;
    logic [slfp_pkg::BYTE_W-1:0]      checksum_reg, checksum_next;
    logic [slfp_pkg::BYTE_W-1:0]      count_inc;
    logic                             present;

    assign count_inc = count_reg + 8'd1;
    assign present   = (length_reg >= slfp_pkg::BYTE_W'(slfp_pkg::AZ_BYTES));

    // Next state for one accepted byte
    always_comb
    begin
        phase_next    = phase_reg;
        type_next     = type_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        azimuth_next  = azimuth_reg;
        checksum_next = checksum_reg;
        emit          = 1'b0;

        if (byte_valid)
        begin
            unique case (phase_reg)
                slfp_pkg::PH_SYNC1:
                begin
                    if (rx_byte == cfg.second_sync)
                    begin
                        phase_next = slfp_pkg::PH_TYPE;
                    end
                    else
                    begin
                        phase_next    = slfp_pkg::PH_HUNT;
                        type_next     = '0;
                        length_next   = '0;
                        count_next    = '0;
                        azimuth_next  = '0;
                        checksum_next = '0;
                    end
                end
                slfp_pkg::PH_TYPE:
                begin
                    type_next  = rx_byte;
                    phase_next = slfp_pkg::PH_LENGTH;
                end
                slfp_pkg::PH_LENGTH:
                begin
                    length_next = rx_byte;
                    count_next  = '0;
                    phase_next  = (rx_byte != '0) ? slfp_pkg::PH_PAYLOAD
                                                  : slfp_pkg::PH_CHECK;
                end
                slfp_pkg::PH_PAYLOAD:
                begin
                    // Keep only the first four payload bytes, little-endian
                    if (count_reg < slfp_pkg::BYTE_W'(slfp_pkg::AZ_BYTES))
                    begin
                        case (count_reg[1:0])
                            2'd0:    azimuth_next[7:0]   = rx_byte;
                            2'd1:    azimuth_next[15:8]  = rx_byte;
                            2'd2:    azimuth_next[23:16] = rx_byte;
                            default: azimuth_next[31:24] = rx_byte;
                        endcase
                    end
                    count_next = count_inc;
                    if (count_inc >= length_reg)
                    begin
                        phase_next = slfp_pkg::PH_CHECK;
                    end
                end
                slfp_pkg::PH_CHECK:
                begin
                    checksum_next = rx_byte;
                    phase_next    = slfp_pkg::PH_END;
                end
                slfp_pkg::PH_END:
                begin
                    // Good or bad end byte, the frame state is dropped
                    emit          = (rx_byte == cfg.end_byte);
                    phase_next    = slfp_pkg::PH_HUNT;
                    type_next     = '0;
                    length_next   = '0;
                    count_next    = '0;
                    azimuth_next  = '0;
                    checksum_next = '0;
                end
                default:
                begin
                    phase_next = (rx_byte == cfg.first_sync) ? slfp_pkg::PH_SYNC1
                                                             : slfp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= slfp_pkg::PH_HUNT;
            type_reg     <= '0;
            length_reg   <= '0;
            count_reg    <= '0;
            azimuth_reg  <= '0;
            checksum_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            type_reg     <= type_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            azimuth_reg  <= azimuth_next;
            checksum_reg <= checksum_next;
        end
    end

    // Result as seen when the end byte arrives
    always_comb
    begin
        result.frame_type      = type_reg;
        result.payload_length  = length_reg;
        result.checksum_value  = checksum_reg;
        result.azimuth_bits    = present ? azimuth_reg : '0;
        result.azimuth_present = present;
    end

    assign phase = phase_reg;

endmodule

`default_nettype wire

/* rtl/core/sync_length_frame_parser.sv */
// Top level of the sync/length frame parser: config registers, tracker, result register.
// Depends on slfp_pkg and slfp_tracker.
//
// Channel  Dir  Signals                          Transfer
// s_*      in   s_tvalid s_tready s_tdata[7:0]   one received byte
// m_*      out  m_tvalid m_tready m_tdata m_tuser one completed frame
// cfg_*    in   cfg_valid cfg_ready cfg_index cfg_data  register write
//
// One byte per cycle while s_tready is high; each byte updates the frame state in the cycle it is taken.
// A frame result shows on m_* the cycle after its end byte is taken.
// The result register sets the stall: bytes are taken while it is empty or being read.
// Reset puts the tracker in hunt and loads the default framing bytes.
`default_nettype none

module sync_length_frame_parser
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [7:0]                            s_tdata,   // [7:0] rx_byte
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // [7:0] frame_type, [15:8] payload_length, [23:16] checksum_value,
    // [55:24] azimuth_bits
    output logic [55:0]                           m_tdata,
    output logic [0:0]                            m_tuser,   // [0] azimuth_present
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [slfp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [7:0]                            cfg_data
);

    slfp_pkg::cfg_t    cfg_reg;
    slfp_pkg::result_t result;
    slfp_pkg::result_t out_reg;
    slfp_pkg::phase_t  phase;
    logic              out_valid_reg;
    logic              byte_take;
    logic              emit;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign byte_take = s_tvalid && s_tready;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_sync  <= slfp_pkg::FIRST_SYNC_RESET;
            cfg_reg.second_sync <= slfp_pkg::SECOND_SYNC_RESET;
            cfg_reg.end_byte    <= slfp_pkg::END_BYTE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                slfp_pkg::REG_FIRST_SYNC:  cfg_reg.first_sync  <= cfg_data;
                slfp_pkg::REG_SECOND_SYNC: cfg_reg.second_sync <= cfg_data;
                slfp_pkg::REG_END_BYTE:    cfg_reg.end_byte    <= cfg_data;
                default:                   cfg_reg             <= cfg_reg;
            endcase
        end
    end

    slfp_tracker u_tracker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_take),
        .rx_byte    (s_tdata),
        .cfg        (cfg_reg),
        .emit       (emit),
        .result     (result),
        .phase      (phase)
    );

    // Result register: load on a good end byte, clear once the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.azimuth_bits, out_reg.checksum_value,
                       out_reg.payload_length, out_reg.frame_type};
    assign m_tuser  = out_reg.azimuth_present;

    // A finished frame always returns the tracker to hunting
    a_emit_then_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> phase == slfp_pkg::PH_HUNT)
        else $error("tracker not hunting after a frame result");

    // A result is only produced while the end byte is expected
    a_emit_in_end: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (phase == slfp_pkg::PH_END && byte_take))
        else $error("frame result outside the end phase");

    // A short payload carries no azimuth bits
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[55:24] == '0 && m_tdata[15:8] < 8'd4))
        else $error("short payload with azimuth bits set");

    // The payload phase is never entered with a zero length
    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase == slfp_pkg::PH_PAYLOAD) |-> (result.payload_length != '0))
        else $error("payload phase entered with zero length");

endmodule

`default_nettype wire
